// ===== design/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

  // Screen geometry and tab spacing.
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;

  // Field widths of the words on both channels.
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 8;
  localparam int ROW_IN_W = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int ATTR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int DATA_W   = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  // Cell index before truncation to the address width.
  localparam int ADDR_FULL_W = ROW_W + COL_W;

  localparam int NUM_STOPS = COLUMNS / TAB_WIDTH;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h1b;

  localparam logic [VALUE_W-1:0] CH_BS  = 8'd8;
  localparam logic [VALUE_W-1:0] CH_TAB = 8'd9;
  localparam logic [VALUE_W-1:0] CH_LF  = 8'd10;
  localparam logic [VALUE_W-1:0] CH_CR  = 8'd13;

  localparam int NUM_STYLES = 6;
  localparam int REV_PAIRS  = 3;

  // Styles in order: normal, bold, dim, reverse normal, reverse bold, reverse dim.
  // Row 0 is the color set, row 1 the black-and-white set.
  localparam logic [ATTR_W-1:0] STYLE_TABLE [2][NUM_STYLES] = '{
    '{8'h1b, 8'h1f, 8'h0f, 8'h13, 8'h4e, 8'h70},
    '{8'h07, 8'h0f, 8'h05, 8'h57, 8'h5f, 8'h70}
  };

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 3'd0,
    KIND_MOVE  = 3'd1,
    KIND_SET   = 3'd2,
    KIND_FG    = 3'd3,
    KIND_BG    = 3'd4,
    KIND_REV   = 3'd5,
    KIND_UNREV = 3'd6,
    KIND_STYLE = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [VALUE_W-1:0]   value;
    logic [ROW_IN_W-1:0]  row;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ATTR_W-1:0] attr;
  } cursor_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    cursor_t           cursor;
  } result_t;

  // Next tab stop after col, clamped to the last column.
  function automatic logic [COL_W-1:0] next_tab(input logic [COL_W-1:0] col);
    logic [COL_W-1:0] res;
    int stop;
    res = COL_MAX;
    for (int k = NUM_STOPS; k >= 1; k--) begin
      stop = k * TAB_WIDTH;
      if (stop < COLUMNS && stop > int'(col)) begin
        res = COL_W'(stop);
      end
    end
    return res;
  endfunction

  // Swap an attribute with its reverse partner in the active set; back selects
  // the reverse-to-plain direction. The first matching pair wins.
  function automatic logic [ATTR_W-1:0] reverse_of(input logic [ATTR_W-1:0] a,
                                                   input logic mono,
                                                   input logic back);
    logic [ATTR_W-1:0] res;
    logic [ATTR_W-1:0] from;
    logic [ATTR_W-1:0] to;
    res = a;
    for (int i = REV_PAIRS - 1; i >= 0; i--) begin
      from = back ? STYLE_TABLE[mono][i + REV_PAIRS] : STYLE_TABLE[mono][i];
      to   = back ? STYLE_TABLE[mono][i] : STYLE_TABLE[mono][i + REV_PAIRS];
      if (a == from) begin
        res = to;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/tcw_in_stage.sv =====
`default_nettype none

module tcw_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tcw_pkg::item_t  in_item,
  input  wire logic            advance,
  output logic                 item_valid,
  output tcw_pkg::item_t       item
);
  import tcw_pkg::*;

  logic  valid_r;
  item_t item_r;

  // A word may enter when the stage is empty or the held one moves on in the same cycle.
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/tcw_exec.sv =====
`default_nettype none

module tcw_exec (
  input  wire tcw_pkg::item_t   item,
  input  wire tcw_pkg::cursor_t cur,
  input  wire logic             mono,
  output tcw_pkg::cursor_t      cur_nxt,
  output tcw_pkg::result_t      res
);
  import tcw_pkg::*;

  logic                   we;
  logic [ADDR_FULL_W-1:0] cell_idx;

  assign cell_idx = ADDR_FULL_W'(cur.row) * ADDR_FULL_W'(COLUMNS) + ADDR_FULL_W'(cur.col);

  always_comb begin
    cur_nxt = cur;
    we      = 1'b0;
    unique case (item.kind)
      KIND_PUT: begin
        priority if (item.value == CH_BS) begin
          if (cur.col != '0) cur_nxt.col = cur.col - COL_W'(1);
        end else if (item.value == CH_CR) begin
          cur_nxt.col = '0;
        end else if (item.value == CH_LF) begin
          if (cur.row < ROW_MAX) cur_nxt.row = cur.row + ROW_W'(1);
        end else if (item.value == CH_TAB) begin
          cur_nxt.col = next_tab(cur.col);
        end else begin
          we = 1'b1;
          if (cur.col < COL_MAX) cur_nxt.col = cur.col + COL_W'(1);
        end
      end
      KIND_MOVE: begin
        if (item.row < ROW_IN_W'(ROWS)) cur_nxt.row = item.row[ROW_W-1:0];
        if (item.value < VALUE_W'(COLUMNS)) cur_nxt.col = item.value[COL_W-1:0];
      end
      KIND_SET:   cur_nxt.attr = item.value;
      KIND_FG:    cur_nxt.attr = {cur.attr[7:4], item.value[3:0]};
      KIND_BG:    cur_nxt.attr = {item.value[3:0], cur.attr[3:0]};
      KIND_REV:   cur_nxt.attr = reverse_of(cur.attr, mono, 1'b0);
      KIND_UNREV: cur_nxt.attr = reverse_of(cur.attr, mono, 1'b1);
      KIND_STYLE: begin
        if (item.value < VALUE_W'(NUM_STYLES)) begin
          cur_nxt.attr = STYLE_TABLE[mono][item.value[2:0]];
        end
      end
      default: ;
    endcase
  end

  // Address and data read as zero on words that write nothing.
  always_comb begin
    res.write_enable  = we;
    res.write_address = we ? cell_idx[ADDR_W-1:0] : '0;
    res.write_data    = we ? {cur.attr, item.value} : '0;
    res.cursor        = cur_nxt;
  end

endmodule

`default_nettype wire

// ===== design/tcw_out_stage.sv =====
`default_nettype none

module tcw_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  wire tcw_pkg::result_t  res,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tcw_pkg::result_t       out_res
);
  import tcw_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/text_console_char_writer.sv =====
// Flow: a word accepted into the input register passes through the command logic
// into the result register when the output stage can advance, and is then offered.
// Throughput: one word per cycle while the output is taken; the cursor and
// attribute registers update through one pass of the command logic per word.
// Reset (synchronous, active low): cursor at column 0, row 0, attribute 0x1b,
// color mode, both pipeline registers empty.
`default_nettype none

module text_console_char_writer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // value [7:0], row [15:8]
  input  wire logic [tcw_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind [2:0]
  input  wire logic [tcw_pkg::KIND_W-1:0]       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // write_address [10:0], write_data [26:11], cursor_col [33:27],
  // cursor_row [38:34], attribute [46:39], zero [47]
  output logic [tcw_pkg::OUT_DATA_W-1:0]        out_tdata,
  // write_enable [0]
  output logic                                  out_tuser,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_wdata
);
  import tcw_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    step;
  cursor_t cur_r;
  cursor_t cur_nxt;
  logic    mono_r;
  result_t res;
  result_t out_res;

  assign in_item.kind  = kind_t'(in_tuser);
  assign in_item.value = in_tdata[7:0];
  assign in_item.row   = in_tdata[15:8];

  tcw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tcw_exec u_exec (
    .item    (item),
    .cur     (cur_r),
    .mono    (mono_r),
    .cur_nxt (cur_nxt),
    .res     (res)
  );

  tcw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // The cursor state commits in the same cycle its result enters the output register.
  assign step = item_valid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.col  <= '0;
      cur_r.row  <= '0;
      cur_r.attr <= ATTR_RESET;
      mono_r     <= 1'b0;
    end else begin
      if (step) begin
        cur_r <= cur_nxt;
      end
      if (cfg_we) begin
        mono_r <= cfg_wdata;
      end
    end
  end

  assign out_tuser = out_res.write_enable;
  assign out_tdata = {1'b0, out_res.cursor.attr, out_res.cursor.row, out_res.cursor.col,
                      out_res.write_data, out_res.write_address};

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r.col <= COL_MAX)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r.row <= ROW_MAX)
    else $error("cursor row out of range");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(cur_r))
    else $error("cursor state changed without a word moving on");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_res.cursor == cur_r)
    else $error("reported cursor differs from committed state");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_res.write_enable |->
      out_res.write_address == '0 && out_res.write_data == '0)
    else $error("non-write word carries address or data");

endmodule

`default_nettype wire
